>>> design/ifsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ifsc_pkg - shared types and constants of the idle/flag stream checker
// Byte lane count, idle run limits, register indexes and the structs that
// pass between the register block, the byte lanes and the merge stage.
// ----------------------------------------------------------------------------
package ifsc_pkg;

   localparam int LANES      = 4;
   localparam int BYTE_W     = 8;
   localparam int WORD_W     = LANES * BYTE_W;
   localparam int RUN_W      = 5;
   localparam int ADDR_W     = 4;
   localparam int CSR_DATA_W = 32;
   localparam int BPP_W      = 2;

   // idle runs required between flags
   localparam logic [RUN_W-1:0] IDLES_NARROW = 5'd7;
   localparam logic [RUN_W-1:0] IDLES_WIDE   = 5'd15;
   localparam logic [RUN_W-1:0] RUN_MAX      = 5'd31;

   // packet width code that selects the long idle run
   localparam logic [BPP_W-1:0] BPP_WIDE  = 2'd2;
   localparam logic [BPP_W-1:0] BPP_RESET = 2'd1;

   // register indexes (byte address / 4)
   typedef enum logic [1:0] {
      REG_FLAG_CHAR = 2'd0,
      REG_IDLE_CHAR = 2'd1,
      REG_BPP       = 2'd2
   } reg_index_type;

   // framing scan states
   typedef enum logic [1:0] {
      SCAN_SEARCH     = 2'd0,
      SCAN_AFTER_FLAG = 2'd1,
      SCAN_ERROR      = 2'd2
   } scan_state_type;

   typedef struct packed {
      logic [BYTE_W-1:0] flag_char;
      logic [BYTE_W-1:0] idle_char;
      logic [BPP_W-1:0]  bytes_per_packet;
   } cfg_type;

   typedef struct packed {
      logic is_idle;
      logic is_flag;
   } byte_class_type;

endpackage
`default_nettype wire

>>> design/idle_flag_stream_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// idle_flag_stream_checker - idle/flag framing checker for captured words
// Four byte lanes classify a 32-bit word and a merge stage runs the
// framing state across them; one pass/fail word comes out per input word.
// ----------------------------------------------------------------------------
// The checker takes one 32-bit word per clock while not stalled and returns
// its result from an output register in the cycle after acceptance; the rate
// is set by the merge stage, which steps all four bytes of a word through the
// framing state combinationally. Input is stalled only while a result waits and
// the output side is stalling. pattern_ok is the running verdict including
// every byte of the current word; vector_end marks the result of the word
// flagged last, after which the framing state starts over. Registers
// (flag at 0x0, idle at 0x4, packet width at 0x8) must be written while
// no word is in flight.
// ----------------------------------------------------------------------------
module idle_flag_stream_checker (
   input  wire                             clock,
   input  wire                             reset,
   // input words
   input  wire                             req_valid,
   output logic                            req_stall,
   input  wire  [ifsc_pkg::WORD_W-1:0]     req_data_word,
   input  wire                             req_last_word,
   // results
   output logic                            rsp_valid,
   input  wire                             rsp_stall,
   output logic                            rsp_pattern_ok,
   output logic                            rsp_vector_end,
   // configuration
   input  wire                             psel,
   input  wire                             penable,
   input  wire                             pwrite,
   input  wire  [ifsc_pkg::ADDR_W-1:0]     paddr,
   input  wire  [ifsc_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [ifsc_pkg::CSR_DATA_W-1:0] prdata,
   output logic                            pready
);

   ifsc_pkg::cfg_type           cfg;
   ifsc_pkg::byte_class_type    lane_class [ifsc_pkg::LANES];
   logic [ifsc_pkg::RUN_W-1:0]  needed;
   logic                        accept;
   logic                        word_ok;
   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   logic                        rsp_ok_ff;
   logic                        rsp_end_ff;

   ifsc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // one classifier per byte of the word
   for (genvar g = 0; g < ifsc_pkg::LANES; g++) begin : g_lane
      ifsc_byte_lane u_lane (
         .byte_in    (req_data_word[g*ifsc_pkg::BYTE_W +: ifsc_pkg::BYTE_W]),
         .flag_char  (cfg.flag_char),
         .idle_char  (cfg.idle_char),
         .byte_class (lane_class[g])
      );
   end

   assign needed = (cfg.bytes_per_packet == ifsc_pkg::BPP_WIDE) ?
                   ifsc_pkg::IDLES_WIDE : ifsc_pkg::IDLES_NARROW;

   ifsc_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .last_word  (req_last_word),
      .needed     (needed),
      .lane_class (lane_class),
      .pattern_ok (word_ok)
   );

   // take a word whenever the output register is free or being drained
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // load the result word
   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_ok_ff  <= word_ok;
         rsp_end_ff <= req_last_word;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_pattern_ok = rsp_ok_ff;
   assign rsp_vector_end = rsp_end_ff;

endmodule
`default_nettype wire

>>> design/ifsc_csr.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ifsc_csr - configuration registers
// APB-style write and read of the flag character, idle character and
// packet width.
// ----------------------------------------------------------------------------
module ifsc_csr (
   input  wire                                 clock,
   input  wire                                 reset,
   input  wire                                 psel,
   input  wire                                 penable,
   input  wire                                 pwrite,
   input  wire  [ifsc_pkg::ADDR_W-1:0]         paddr,
   input  wire  [ifsc_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [ifsc_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready,
   output ifsc_pkg::cfg_type                   cfg
);

   logic [ifsc_pkg::BYTE_W-1:0] flag_char_ff;
   logic [ifsc_pkg::BYTE_W-1:0] idle_char_ff;
   logic [ifsc_pkg::BPP_W-1:0]  bpp_ff;
   logic                        wr_en;
   logic [1:0]                  reg_sel;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_sel = paddr[3:2];

   // write the selected register on the access cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         flag_char_ff <= '0;
         idle_char_ff <= '0;
         bpp_ff       <= ifsc_pkg::BPP_RESET;
      end else if (wr_en) begin
         case (reg_sel)
            ifsc_pkg::REG_FLAG_CHAR: flag_char_ff <= pwdata[ifsc_pkg::BYTE_W-1:0];
            ifsc_pkg::REG_IDLE_CHAR: idle_char_ff <= pwdata[ifsc_pkg::BYTE_W-1:0];
            ifsc_pkg::REG_BPP:       bpp_ff       <= pwdata[ifsc_pkg::BPP_W-1:0];
            default: ;
         endcase
      end
   end

   // read back, zero extended
   always_comb begin
      case (reg_sel)
         ifsc_pkg::REG_FLAG_CHAR:
            prdata = {{(ifsc_pkg::CSR_DATA_W-ifsc_pkg::BYTE_W){1'b0}}, flag_char_ff};
         ifsc_pkg::REG_IDLE_CHAR:
            prdata = {{(ifsc_pkg::CSR_DATA_W-ifsc_pkg::BYTE_W){1'b0}}, idle_char_ff};
         ifsc_pkg::REG_BPP:
            prdata = {{(ifsc_pkg::CSR_DATA_W-ifsc_pkg::BPP_W){1'b0}}, bpp_ff};
         default:
            prdata = '0;
      endcase
   end

   assign cfg.flag_char        = flag_char_ff;
   assign cfg.idle_char        = idle_char_ff;
   assign cfg.bytes_per_packet = bpp_ff;

endmodule
`default_nettype wire

>>> design/ifsc_byte_lane.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ifsc_byte_lane - byte classifier
// Marks one byte of the word as idle, flag or neither. A byte that matches
// both characters counts as idle.
// ----------------------------------------------------------------------------
module ifsc_byte_lane (
   input  wire  [ifsc_pkg::BYTE_W-1:0] byte_in,
   input  wire  [ifsc_pkg::BYTE_W-1:0] flag_char,
   input  wire  [ifsc_pkg::BYTE_W-1:0] idle_char,
   output ifsc_pkg::byte_class_type    byte_class
);

   logic idle_hit;

   assign idle_hit           = (byte_in == idle_char);
   assign byte_class.is_idle = idle_hit;
   assign byte_class.is_flag = !idle_hit && (byte_in == flag_char);

endmodule
`default_nettype wire

>>> design/ifsc_merge.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ifsc_merge - framing state merge
// Walks the four lane classes through the framing state, lowest byte
// first, and holds the scan state between words.
// ----------------------------------------------------------------------------
module ifsc_merge (
   input  wire                                clock,
   input  wire                                reset,
   input  wire                                accept,
   input  wire                                last_word,
   input  wire  [ifsc_pkg::RUN_W-1:0]         needed,
   input  var   ifsc_pkg::byte_class_type     lane_class [ifsc_pkg::LANES],
   output logic                               pattern_ok
);

   typedef struct packed {
      ifsc_pkg::scan_state_type  state;
      logic [ifsc_pkg::RUN_W-1:0] idle_run;
      logic                       flag_seen;
   } scan_type;

   scan_type scan_ff;
   scan_type scan_in;
   scan_type chain [ifsc_pkg::LANES+1];

   // advance the scan by one byte
   function automatic scan_type step_byte(scan_type s, ifsc_pkg::byte_class_type c,
                                          logic [ifsc_pkg::RUN_W-1:0] need);
      scan_type                   n;
      logic [ifsc_pkg::RUN_W-1:0] run_inc;
      n       = s;
      run_inc = (s.idle_run != ifsc_pkg::RUN_MAX) ? s.idle_run + 5'd1 : s.idle_run;
      case (s.state)
         ifsc_pkg::SCAN_SEARCH: begin
            if (c.is_idle) begin
               n.idle_run = run_inc;
               if (run_inc > need) n.state = ifsc_pkg::SCAN_ERROR;
            end else if (c.is_flag) begin
               if (s.flag_seen && (s.idle_run != need)) begin
                  n.state = ifsc_pkg::SCAN_ERROR;
               end else begin
                  n.flag_seen = 1'b1;
                  n.state     = ifsc_pkg::SCAN_AFTER_FLAG;
               end
            end else begin
               n.state = ifsc_pkg::SCAN_ERROR;
            end
         end
         ifsc_pkg::SCAN_AFTER_FLAG: begin
            if (c.is_idle) begin
               n.idle_run = 5'd1;
               n.state    = ifsc_pkg::SCAN_SEARCH;
            end else begin
               n.idle_run = '0;
               n.state    = ifsc_pkg::SCAN_ERROR;
            end
         end
         default: n.state = ifsc_pkg::SCAN_ERROR;
      endcase
      return n;
   endfunction

   // chain the lanes, then clear at the end of a vector
   always_comb begin
      chain[0] = scan_ff;
      for (int i = 0; i < ifsc_pkg::LANES; i++) begin
         chain[i+1] = step_byte(chain[i], lane_class[i], needed);
      end
      pattern_ok = (chain[ifsc_pkg::LANES].state == ifsc_pkg::SCAN_SEARCH) ||
                   (chain[ifsc_pkg::LANES].state == ifsc_pkg::SCAN_AFTER_FLAG);
      scan_in = scan_ff;
      if (accept) begin
         if (last_word) begin
            scan_in.state     = ifsc_pkg::SCAN_SEARCH;
            scan_in.idle_run  = '0;
            scan_in.flag_seen = 1'b0;
         end else begin
            scan_in = chain[ifsc_pkg::LANES];
         end
      end
   end

   // hold the scan state
   always_ff @(posedge clock) begin
      if (reset) begin
         scan_ff.state     <= ifsc_pkg::SCAN_SEARCH;
         scan_ff.idle_run  <= '0;
         scan_ff.flag_seen <= 1'b0;
      end else begin
         scan_ff <= scan_in;
      end
   end

   // end of vector returns the scan to its reset state
   a_clear_on_last: assert property (@(posedge clock) disable iff (reset)
      accept && last_word |=> scan_ff.state == ifsc_pkg::SCAN_SEARCH &&
                              scan_ff.idle_run == '0 && !scan_ff.flag_seen)
      else $error("scan state not cleared after last word");

   // an error stays until the vector ends
   a_error_sticky: assert property (@(posedge clock) disable iff (reset)
      scan_ff.state == ifsc_pkg::SCAN_ERROR && !(accept && last_word)
         |=> scan_ff.state == ifsc_pkg::SCAN_ERROR)
      else $error("framing error dropped inside a vector");

   // the idle run never passes the longest limit by more than one
   a_run_bound: assert property (@(posedge clock) disable iff (reset)
      scan_ff.idle_run <= ifsc_pkg::IDLES_WIDE + 5'd1)
      else $error("idle run out of range");

endmodule
`default_nettype wire

>>> test/idle_flag_stream_checker_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// idle_flag_stream_checker_tb - self-checking bench for the framing checker
// Drives captured words through the valid/stall input channel, predicts the
// running verdict of every word with its own byte-level framing model and
// checks each result word in order. Registers are rewritten between phases,
// directed framing cases come first, then random vectors with bursty input
// and a patterned output stall.
// ----------------------------------------------------------------------------
module idle_flag_stream_checker_tb;

   localparam int WORD_TARGET    = 1300;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int LONG_HOLD      = 120;

   typedef struct {
      logic [ifsc_pkg::WORD_W-1:0] data;
      logic                        last;
      bit                          drain;
   } word_item_type;

   typedef struct packed {
      logic pattern_ok;
      logic vector_end;
   } verdict_type;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_valid = 1'b0;
   logic                            req_stall;
   logic [ifsc_pkg::WORD_W-1:0]     req_data_word = '0;
   logic                            req_last_word = 1'b0;
   logic                            rsp_valid;
   logic                            rsp_stall = 1'b0;
   logic                            rsp_pattern_ok;
   logic                            rsp_vector_end;
   logic                            psel = 1'b0;
   logic                            penable = 1'b0;
   logic                            pwrite = 1'b0;
   logic [ifsc_pkg::ADDR_W-1:0]     paddr = '0;
   logic [ifsc_pkg::CSR_DATA_W-1:0] pwdata = '0;
   logic [ifsc_pkg::CSR_DATA_W-1:0] prdata;
   logic                            pready;

   // register copy and framing state of the predictor
   ifsc_pkg::cfg_type           cfg = '{flag_char: '0, idle_char: '0,
                                        bytes_per_packet: ifsc_pkg::BPP_RESET};
   ifsc_pkg::scan_state_type    scan_st = ifsc_pkg::SCAN_SEARCH;
   logic [ifsc_pkg::RUN_W-1:0]  idle_cnt = '0;
   logic                        flag_hit = 1'b0;

   word_item_type     pending_words[$];
   verdict_type       expected_verdicts[$];
   int                n_queued = 0;
   int                n_predicted = 0;
   int                n_checked = 0;
   int                n_errors = 0;

   idle_flag_stream_checker DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data_word  (req_data_word),
      .req_last_word  (req_last_word),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_pattern_ok (rsp_pattern_ok),
      .rsp_vector_end (rsp_vector_end),
      .psel           (psel),
      .penable        (penable),
      .pwrite         (pwrite),
      .paddr          (paddr),
      .pwdata         (pwdata),
      .prdata         (prdata),
      .pready         (pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Step the four bytes of one word through the framing state, LSB first.
   function automatic verdict_type framing_step(input logic [ifsc_pkg::WORD_W-1:0] data,
                                                input logic last);
      logic [ifsc_pkg::BYTE_W-1:0] b;
      logic [ifsc_pkg::RUN_W-1:0]  need;
      verdict_type                 v;
      int                          lane;
      need = (cfg.bytes_per_packet == ifsc_pkg::BPP_WIDE) ?
             ifsc_pkg::IDLES_WIDE : ifsc_pkg::IDLES_NARROW;
      for (lane = 0; lane < ifsc_pkg::LANES; lane++) begin
         b = data[lane*ifsc_pkg::BYTE_W +: ifsc_pkg::BYTE_W];
         case (scan_st)
            ifsc_pkg::SCAN_SEARCH: begin
               // equal idle and flag characters resolve to idle here
               if (b == cfg.idle_char) begin
                  if (idle_cnt != ifsc_pkg::RUN_MAX) idle_cnt = idle_cnt + 1'b1;
                  if (idle_cnt > need) scan_st = ifsc_pkg::SCAN_ERROR;
               end else if (b == cfg.flag_char) begin
                  // the first flag of a vector is taken whatever the run
                  if (flag_hit && idle_cnt != need) begin
                     scan_st = ifsc_pkg::SCAN_ERROR;
                  end else begin
                     flag_hit = 1'b1;
                     scan_st  = ifsc_pkg::SCAN_AFTER_FLAG;
                  end
               end else begin
                  scan_st = ifsc_pkg::SCAN_ERROR;
               end
            end
            ifsc_pkg::SCAN_AFTER_FLAG: begin
               if (b == cfg.idle_char) begin
                  idle_cnt = 5'd1;
                  scan_st  = ifsc_pkg::SCAN_SEARCH;
               end else begin
                  idle_cnt = '0;
                  scan_st  = ifsc_pkg::SCAN_ERROR;
               end
            end
            default: scan_st = ifsc_pkg::SCAN_ERROR;
         endcase
      end
      v.pattern_ok = (scan_st == ifsc_pkg::SCAN_SEARCH) ||
                     (scan_st == ifsc_pkg::SCAN_AFTER_FLAG);
      v.vector_end = last;
      // the last word closes the vector
      if (last) begin
         scan_st  = ifsc_pkg::SCAN_SEARCH;
         idle_cnt = '0;
         flag_hit = 1'b0;
      end
      return v;
   endfunction

   function automatic logic [ifsc_pkg::WORD_W-1:0] pack_bytes(
      input logic [ifsc_pkg::BYTE_W-1:0] b0, input logic [ifsc_pkg::BYTE_W-1:0] b1,
      input logic [ifsc_pkg::BYTE_W-1:0] b2, input logic [ifsc_pkg::BYTE_W-1:0] b3);
      return {b3, b2, b1, b0};
   endfunction

   task automatic queue_word(input logic [ifsc_pkg::WORD_W-1:0] data, input logic last,
                             input bit drain);
      word_item_type w;
      w.data  = data;
      w.last  = last;
      w.drain = drain;
      pending_words = {pending_words, w};
      n_queued++;
   endtask

   // Setup cycle, then access cycle; the write lands when pready is seen.
   task automatic csr_write(input ifsc_pkg::reg_index_type idx,
                            input logic [ifsc_pkg::BYTE_W-1:0] value);
      @(posedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 2'b00};
      pwdata  <= {24'h0, value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      case (idx)
         ifsc_pkg::REG_FLAG_CHAR: cfg.flag_char = value;
         ifsc_pkg::REG_IDLE_CHAR: cfg.idle_char = value;
         default:                 cfg.bytes_per_packet = value[ifsc_pkg::BPP_W-1:0];
      endcase
   endtask

   task automatic configure(input logic [ifsc_pkg::BYTE_W-1:0] flag_c,
                            input logic [ifsc_pkg::BYTE_W-1:0] idle_c,
                            input logic [ifsc_pkg::BPP_W-1:0] bpp);
      csr_write(ifsc_pkg::REG_FLAG_CHAR, flag_c);
      csr_write(ifsc_pkg::REG_IDLE_CHAR, idle_c);
      csr_write(ifsc_pkg::REG_BPP, {6'h0, bpp});
      @(negedge clock);
   endtask

   // Hold until no word is pending, offered or awaiting its result.
   task automatic wait_drained();
      do @(negedge clock);
      while (pending_words.size() != 0 || req_valid || expected_verdicts.size() != 0);
   endtask

   // One vector: mostly clean framing with random phase and length, some
   // with corrupted bytes, some pure noise.
   task automatic queue_random_vector(input bit drain_first);
      int                          n_words;
      int                          kind;
      int                          pos;
      int                          need;
      int                          k;
      int                          lane;
      logic [ifsc_pkg::BYTE_W-1:0] b;
      logic [ifsc_pkg::WORD_W-1:0] w;
      need    = (cfg.bytes_per_packet == ifsc_pkg::BPP_WIDE) ?
                int'(ifsc_pkg::IDLES_WIDE) : int'(ifsc_pkg::IDLES_NARROW);
      n_words = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 8);
      kind    = $urandom_range(0, 9);
      pos     = $urandom_range(0, need);
      for (k = 0; k < n_words; k++) begin
         if (kind == 9) begin
            w = $urandom;
         end else begin
            for (lane = 0; lane < ifsc_pkg::LANES; lane++) begin
               if (kind == 8) begin
                  case ($urandom_range(0, 2))
                     0:       b = cfg.idle_char;
                     1:       b = cfg.flag_char;
                     default: b = 8'($urandom_range(0, 255));
                  endcase
               end else begin
                  b   = (pos == 0) ? cfg.flag_char : cfg.idle_char;
                  pos = (pos == need) ? 0 : pos + 1;
                  if (kind >= 6 && $urandom_range(0, 23) == 0) begin
                     if ($urandom_range(0, 1) == 0) b = 8'($urandom_range(0, 255));
                     else b = (b == cfg.flag_char) ? cfg.idle_char : cfg.flag_char;
                  end
               end
               w[lane*ifsc_pkg::BYTE_W +: ifsc_pkg::BYTE_W] = b;
            end
         end
         queue_word(w, k == n_words - 1, drain_first && k == 0);
      end
   endtask

   // Driver: bursts of words with random gaps, payload held while stalled.
   int  gap_left = 0;
   int  burst_left = 1;
   bit  drained_now;
   word_item_type next_word;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_verdicts = {expected_verdicts,
                                 framing_step(req_data_word, req_last_word)};
            n_predicted++;
         end
         drained_now = (n_predicted == n_checked + ((rsp_valid && !rsp_stall) ? 1 : 0));
         if (!req_valid || !req_stall) begin
            if (gap_left != 0) begin
               gap_left--;
               req_valid <= 1'b0;
            end else if (pending_words.size() != 0 &&
                         (!pending_words[0].drain || drained_now)) begin
               next_word = pending_words.pop_front();
               req_valid     <= 1'b1;
               req_data_word <= next_word.data;
               req_last_word <= next_word.last;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor and output stall pattern.
   verdict_type want;
   int  hold_left = 0;
   bit  long_hold_done = 1'b0;
   int  window_left = 0;
   int  stall_mode = 0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_verdicts.size() == 0) begin
               $error("result word with no expectation: pattern_ok=%0b vector_end=%0b",
                      rsp_pattern_ok, rsp_vector_end);
               n_errors++;
            end else begin
               want = expected_verdicts.pop_front();
               if (rsp_pattern_ok !== want.pattern_ok) begin
                  $error("pattern_ok mismatch: expected %0b, actual %0b",
                         want.pattern_ok, rsp_pattern_ok);
                  n_errors++;
               end
               if (rsp_vector_end !== want.vector_end) begin
                  $error("vector_end mismatch: expected %0b, actual %0b",
                         want.vector_end, rsp_vector_end);
                  n_errors++;
               end
            end
            n_checked <= n_checked + 1;
         end
         // one long hold so the input side backs up
         if (!long_hold_done && n_checked >= 500) begin
            hold_left      = LONG_HOLD;
            long_hold_done = 1'b1;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            if (window_left == 0) begin
               stall_mode  = $urandom_range(0, 3);
               window_left = $urandom_range(20, 80);
            end else begin
               window_left--;
            end
            case (stall_mode)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 3) == 0);
               2:       rsp_stall <= ($urandom_range(0, 3) != 0);
               default: rsp_stall <= !rsp_stall;
            endcase
         end
      end
   end

   // Watchdog: end the run when nothing moves for too long.
   int idle_cycles = 0;

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Stimulus phases
   logic [ifsc_pkg::BYTE_W-1:0] fc;
   logic [ifsc_pkg::BYTE_W-1:0] ic;
   int                          phase_words;
   int                          n_vec;
   int                          n_phase;

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings: equal characters, eight idles overrun the narrow run
      queue_word(32'h0000_0000, 1'b0, 1'b0);
      queue_word(32'h0000_0000, 1'b1, 1'b0);
      wait_drained();

      // narrow mode, extreme characters
      configure(8'hFF, 8'h00, 2'd1);
      fc = cfg.flag_char;
      ic = cfg.idle_char;
      // first flag after a short run, then seven idles and a flag
      queue_word(pack_bytes(ic, ic, ic, fc), 1'b0, 1'b0);
      queue_word(pack_bytes(ic, ic, ic, ic), 1'b0, 1'b0);
      queue_word(pack_bytes(ic, ic, ic, fc), 1'b1, 1'b0);
      // six idles: error lands on the final byte
      queue_word(pack_bytes(fc, ic, ic, ic), 1'b0, 1'b0);
      queue_word(pack_bytes(ic, ic, ic, fc), 1'b1, 1'b0);
      // flag right after flag
      queue_word(pack_bytes(fc, fc, ic, ic), 1'b1, 1'b0);
      queue_word(32'hFFFF_FFFF, 1'b1, 1'b0);
      // stray byte, error stays until the vector ends
      queue_word(pack_bytes(8'h5A, ic, ic, ic), 1'b0, 1'b1);
      queue_word(pack_bytes(fc, ic, ic, ic), 1'b1, 1'b0);
      wait_drained();

      // wide mode: fifteen idles between flags
      configure(8'h7E, 8'h3C, ifsc_pkg::BPP_WIDE);
      fc = cfg.flag_char;
      ic = cfg.idle_char;
      queue_word(pack_bytes(fc, ic, ic, ic), 1'b0, 1'b0);
      repeat (3) queue_word(pack_bytes(ic, ic, ic, ic), 1'b0, 1'b0);
      queue_word(pack_bytes(fc, ic, ic, ic), 1'b1, 1'b0);
      wait_drained();

      // odd width code falls back to narrow; equal characters again
      configure(8'hA5, 8'hA5, 2'd3);
      queue_word(32'hA5A5_A5A5, 1'b0, 1'b0);
      queue_word(32'hA5A5_A5A5, 1'b1, 1'b0);
      wait_drained();

      // random phases with fresh settings each time
      n_phase = 0;
      while (n_queued < WORD_TARGET) begin
         fc = 8'($urandom_range(0, 255));
         ic = 8'($urandom_range(0, 255));
         case ($urandom_range(0, 7))
            0: ic = fc;
            1: begin fc = 8'h00; ic = 8'hFF; end
            2: begin fc = 8'hFF; ic = 8'h00; end
            default: ;
         endcase
         configure(fc, ic, (n_phase == 0) ? 2'd0 : 2'($urandom_range(0, 3)));
         phase_words = n_queued + $urandom_range(120, 180);
         n_vec = 0;
         while (n_queued < phase_words) begin
            queue_random_vector(n_vec == 5);
            n_vec++;
         end
         wait_drained();
         n_phase++;
      end

      repeat (4) @(posedge clock);
      if (n_errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

>>> idle_flag_stream_checker.f
design/ifsc_pkg.sv
design/ifsc_csr.sv
design/ifsc_byte_lane.sv
design/ifsc_merge.sv
design/idle_flag_stream_checker.sv
test/idle_flag_stream_checker_tb.sv
